### rtl/skte_pkg.sv
// Package for the sorted key table engine: operation and status codes,
// sequencer state and phase types and default sizes. No dependencies.
`default_nettype none
package skte_pkg;

  localparam int unsigned CapacityDef  = 256;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned ValueBitsDef = 32;

  localparam logic [3:0] OpGet     = 4'd0;
  localparam logic [3:0] OpGte     = 4'd1;
  localparam logic [3:0] OpLte     = 4'd2;
  localparam logic [3:0] OpGt      = 4'd3;
  localparam logic [3:0] OpLt      = 4'd4;
  localparam logic [3:0] OpInsert  = 4'd5;
  localparam logic [3:0] OpDelete  = 4'd6;
  localparam logic [3:0] OpMGet    = 4'd7;
  localparam logic [3:0] OpMGetAt  = 4'd8;
  localparam logic [3:0] OpMAppend = 4'd9;
  localparam logic [3:0] OpMPrep   = 4'd10;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMiss    = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StPresent = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a word
    S_XREQ,   // exact search: issue probe read
    S_XCMP,   // exact search: compare probe
    S_BREQ,   // bound search: issue probe read
    S_BCMP,   // bound search: compare probe
    S_DECIDE, // work out hit position and action
    S_FREQ,   // read the final entry
    S_FGET,   // latch the final entry
    S_SHIFT,  // move entries one place, a read then a write per entry
    S_WRITE,  // write the new entry
    S_OUT     // hold the result word
  } state_e;

  // Which search, if any, has finished when the sequencer reaches S_DECIDE.
  typedef enum logic [1:0] {
    PH_START,
    PH_EXACT,
    PH_BOUND
  } phase_e;

  // Three-way key order as lt and eq; gt is when neither is set.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage
`default_nettype wire

### rtl/skte_cmp.sv
// Shared key comparator of the sorted key table engine.
// Depends on skte_pkg.
`default_nettype none
module skte_cmp #(
  parameter int unsigned KeyBits = skte_pkg::KeyBitsDef
) (
  input  wire logic               key_signed_i,
  input  wire logic [KeyBits-1:0] a_i,
  input  wire logic [KeyBits-1:0] b_i,
  output skte_pkg::cmp_t          res_o
);
  logic [KeyBits-1:0] a_x, b_x;
  // Flipping the sign bit turns a signed compare into an unsigned one.
  assign a_x = {a_i[KeyBits-1] ^ key_signed_i, a_i[KeyBits-2:0]};
  assign b_x = {b_i[KeyBits-1] ^ key_signed_i, b_i[KeyBits-2:0]};
  assign res_o.lt = a_x < b_x;
  assign res_o.eq = a_x == b_x;
endmodule
`default_nettype wire

### rtl/skte_store.sv
// Key and value memory of the sorted key table engine, one port each way.
// Depends on skte_pkg for default sizes only; no submodules.
`default_nettype none
module skte_store #(
  parameter int unsigned Capacity  = skte_pkg::CapacityDef,
  parameter int unsigned KeyBits   = skte_pkg::KeyBitsDef,
  parameter int unsigned ValueBits = skte_pkg::ValueBitsDef,
  localparam int unsigned AW = $clog2(Capacity)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [KeyBits-1:0]   wkey_i,
  input  wire logic [ValueBits-1:0] wval_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [KeyBits-1:0]   rkey_o,
  output logic      [ValueBits-1:0] rval_o
);
  logic [KeyBits-1:0]   key_mem [Capacity];
  logic [ValueBits-1:0] val_mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      val_mem[waddr_i] <= wval_i;
    end
    rkey_o <= key_mem[raddr_i];
    rval_o <= val_mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/sorted_key_table_engine.sv
// Sorted key table engine: keys in ascending order, binary search by one
// shared comparator over a memory with one read and one write port; each
// probe issues a read, then compares. At most log2(Capacity)+1 probes per
// search; lte that misses runs a second search. Inserts move each entry
// above the position up one place and then write; deletes fetch the entry
// and then move the entries above it down. One word at a time.
// Reset empties the table and sets key_signed to 1; memory is not cleared.
`default_nettype none
module sorted_key_table_engine #(
  parameter int unsigned Capacity  = skte_pkg::CapacityDef,
  parameter int unsigned KeyBits   = skte_pkg::KeyBitsDef,
  parameter int unsigned ValueBits = skte_pkg::ValueBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: op[3:0], key[35:4], value[67:36], run_offset[75:68]
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[1:0], position[9:2], found_key[41:10],
  // found_value[73:42], entry_total[82:74]
  output logic [87:0]      m_axis_tdata
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  // Signed index width: holds -1 up to Capacity plus the largest run offset.
  localparam int unsigned IW = ((CW > 8) ? CW : 8) + 2;
  localparam int unsigned KW = (KeyBits < 32) ? KeyBits : 32;
  localparam int unsigned VW = (ValueBits < 32) ? ValueBits : 32;
  localparam logic signed [IW-1:0] NoHit = '1;

  skte_pkg::state_e state_q, state_d;
  skte_pkg::phase_e phase_q, phase_d;

  logic                 key_signed_q;
  logic [CW-1:0]        count_q, count_d;
  logic [3:0]           op_q, op_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic [7:0]           off_q, off_d;
  logic signed [IW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [IW-1:0] eq_q, eq_d, nxt_q, nxt_d, hit_q, hit_d;
  logic                 strict_q, strict_d;
  logic                 ins_q, ins_d;   // shifting up for an insert
  logic                 del_q, del_d;   // delete found: shift after the read
  logic [CW-1:0]        ptr_q, ptr_d;   // shift cursor
  logic                 mv_q, mv_d;     // shift: read issued, write due
  logic [1:0]           stat_q, stat_d;
  logic [KeyBits-1:0]   rk_q, rk_d;
  logic [ValueBits-1:0] rv_q, rv_d;
  logic                 chk_q, chk_d;   // final entry must equal key

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KeyBits-1:0]   wkey, rkey;
  logic [ValueBits-1:0] wval, rval;
  skte_pkg::cmp_t       cmp;
  logic signed [IW-1:0] mid_c, cnt_s;
  logic                 full, exact_op, multi_ins, bound_op;

  skte_store #(.Capacity(Capacity), .KeyBits(KeyBits), .ValueBits(ValueBits)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wkey_i(wkey), .wval_i(wval),
    .raddr_i(raddr), .rkey_o(rkey), .rval_o(rval)
  );

  skte_cmp #(.KeyBits(KeyBits)) u_cmp (
    .key_signed_i(key_signed_q), .a_i(rkey), .b_i(key_q), .res_o(cmp)
  );

  // The probe address is issued in the request cycle, so the compare cycle
  // sees the entry at mid_q.
  assign mid_c     = lo_q + ((hi_q - lo_q) >>> 1);
  assign cnt_s     = $signed(IW'(count_q));
  assign full      = (count_q == CW'(Capacity));
  assign exact_op  = (op_q == skte_pkg::OpGet) || (op_q == skte_pkg::OpGte) ||
                     (op_q == skte_pkg::OpLte) || (op_q == skte_pkg::OpInsert) ||
                     (op_q == skte_pkg::OpDelete);
  assign multi_ins = (op_q == skte_pkg::OpMAppend) || (op_q == skte_pkg::OpMPrep);
  assign bound_op  = (op_q == skte_pkg::OpGt) || (op_q == skte_pkg::OpLt) ||
                     (op_q == skte_pkg::OpMGet) || (op_q == skte_pkg::OpMGetAt) ||
                     (multi_ins && !full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= skte_pkg::S_IDLE;
      key_signed_q <= 1'b1;
      count_q      <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) key_signed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; val_q <= val_d; off_q <= off_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; phase_q <= phase_d;
    eq_q <= eq_d; nxt_q <= nxt_d; hit_q <= hit_d; del_q <= del_d;
    strict_q <= strict_d; ins_q <= ins_d; ptr_q <= ptr_d; mv_q <= mv_d;
    stat_q <= stat_d; rk_q <= rk_d; rv_q <= rv_d; chk_q <= chk_d;
  end

  // Memory read address follows the probe, the shift cursor or the hit.
  always_comb begin
    raddr = mid_c[AW-1:0];
    if (state_q == skte_pkg::S_SHIFT) begin
      raddr = ins_q ? AW'(ptr_q - CW'(1)) : AW'(ptr_q + CW'(1));
    end else if (state_q == skte_pkg::S_FREQ) begin
      raddr = hit_q[AW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skte_pkg::S_IDLE: if (s_axis_tvalid) state_d = skte_pkg::S_DECIDE;
      skte_pkg::S_XREQ:
        state_d = (lo_q <= hi_q) ? skte_pkg::S_XCMP : skte_pkg::S_DECIDE;
      skte_pkg::S_XCMP: state_d = cmp.eq ? skte_pkg::S_DECIDE : skte_pkg::S_XREQ;
      skte_pkg::S_BREQ:
        state_d = (lo_q < hi_q) ? skte_pkg::S_BCMP : skte_pkg::S_DECIDE;
      skte_pkg::S_BCMP: state_d = skte_pkg::S_BREQ;
      skte_pkg::S_DECIDE: begin
        unique case (phase_q)
          skte_pkg::PH_START: begin
            if (exact_op) state_d = skte_pkg::S_XREQ;
            else if (bound_op) state_d = skte_pkg::S_BREQ;
            else state_d = skte_pkg::S_FREQ;
          end
          skte_pkg::PH_EXACT: begin
            if (op_q == skte_pkg::OpLte && eq_q < 0) state_d = skte_pkg::S_BREQ;
            else if (op_q == skte_pkg::OpInsert && eq_q < 0 && !full)
              state_d = skte_pkg::S_SHIFT;
            else state_d = skte_pkg::S_FREQ;
          end
          default: state_d = multi_ins ? skte_pkg::S_SHIFT : skte_pkg::S_FREQ;
        endcase
      end
      skte_pkg::S_SHIFT: begin
        if (ins_q) begin
          if (!mv_q && ptr_q == CW'(hit_q)) state_d = skte_pkg::S_WRITE;
        end else if (!mv_q && (ptr_q + CW'(1)) >= count_q) begin
          state_d = skte_pkg::S_OUT;
        end
      end
      skte_pkg::S_WRITE: state_d = skte_pkg::S_FREQ;
      skte_pkg::S_FREQ:  state_d = skte_pkg::S_FGET;
      skte_pkg::S_FGET:  state_d = del_q ? skte_pkg::S_SHIFT : skte_pkg::S_OUT;
      skte_pkg::S_OUT:   if (m_axis_tready) state_d = skte_pkg::S_IDLE;
      default: ;
    endcase
  end

  // Datapath and sequencing actions.
  always_comb begin
    op_d = op_q; key_d = key_q; val_d = val_q; off_d = off_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; phase_d = phase_q;
    eq_d = eq_q; nxt_d = nxt_q; hit_d = hit_q; del_d = del_q;
    strict_d = strict_q; ins_d = ins_q; ptr_d = ptr_q; mv_d = mv_q;
    stat_d = stat_q; rk_d = rk_q; rv_d = rv_q; chk_d = chk_q;
    count_d = count_q;
    we = 1'b0; waddr = ptr_q[AW-1:0]; wkey = rkey; wval = rval;
    unique case (state_q)
      skte_pkg::S_IDLE: begin
        op_d    = s_axis_tdata[3:0];
        key_d   = KeyBits'(s_axis_tdata[4 +: KW]);
        val_d   = ValueBits'(s_axis_tdata[36 +: VW]);
        off_d   = s_axis_tdata[75:68];
        phase_d = skte_pkg::PH_START;
        stat_d  = skte_pkg::StMiss;
        hit_d   = NoHit;
        chk_d   = 1'b0;
        del_d   = 1'b0;
      end
      skte_pkg::S_XREQ, skte_pkg::S_BREQ: mid_d = mid_c;
      skte_pkg::S_XCMP: begin
        if (cmp.lt) lo_d = mid_q + $signed(IW'(1));
        else if (cmp.eq) eq_d = mid_q;
        else begin
          nxt_d = mid_q;
          hi_d  = mid_q - $signed(IW'(1));
        end
      end
      skte_pkg::S_BCMP: begin
        if (cmp.lt || (strict_q && cmp.eq)) lo_d = mid_q + $signed(IW'(1));
        else hi_d = mid_q;
      end
      skte_pkg::S_DECIDE: begin
        unique case (phase_q)
          skte_pkg::PH_START: begin
            lo_d  = '0;
            eq_d  = NoHit;
            nxt_d = NoHit;
            if (exact_op) begin
              hi_d    = cnt_s - $signed(IW'(1));
              phase_d = skte_pkg::PH_EXACT;
            end else if (bound_op) begin
              hi_d     = cnt_s;
              strict_d = (op_q == skte_pkg::OpGt) || (op_q == skte_pkg::OpMAppend);
              phase_d  = skte_pkg::PH_BOUND;
            end else begin
              // A multimap insert that gets here found the table full.
              if (multi_ins) stat_d = skte_pkg::StFull;
              hit_d = NoHit;
            end
          end
          skte_pkg::PH_EXACT: begin
            unique case (op_q)
              skte_pkg::OpGet: hit_d = eq_q;
              skte_pkg::OpGte: hit_d = (eq_q >= 0) ? eq_q : nxt_q;
              skte_pkg::OpLte: begin
                hit_d = eq_q;
                if (eq_q < 0) begin
                  // No exact match: the last smaller key comes from a bound search.
                  lo_d = '0; hi_d = cnt_s; strict_d = 1'b0;
                  phase_d = skte_pkg::PH_BOUND;
                end
              end
              skte_pkg::OpInsert: begin
                if (eq_q >= 0) begin
                  hit_d  = eq_q;
                  stat_d = skte_pkg::StPresent;
                end else if (full) begin
                  hit_d  = NoHit;
                  stat_d = skte_pkg::StFull;
                end else begin
                  hit_d = (nxt_q >= 0) ? nxt_q : cnt_s;
                  ins_d = 1'b1; mv_d = 1'b0; ptr_d = count_q;
                end
              end
              skte_pkg::OpDelete: begin
                hit_d = eq_q;
                if (eq_q >= 0) begin
                  // Fetch the removed entry first, then close the gap.
                  ins_d = 1'b0; mv_d = 1'b0; del_d = 1'b1; ptr_d = CW'(eq_q);
                end
              end
              default: hit_d = NoHit;
            endcase
          end
          default: begin
            // Bound search done: lo is the first index at or past the key (past it when strict).
            unique case (op_q)
              skte_pkg::OpGt: hit_d = lo_q;
              skte_pkg::OpLt, skte_pkg::OpLte: hit_d = lo_q - $signed(IW'(1));
              skte_pkg::OpMGet: begin
                hit_d = lo_q;
                chk_d = 1'b1;
              end
              skte_pkg::OpMGetAt: begin
                hit_d = lo_q + $signed(IW'(off_q));
                chk_d = 1'b1;
              end
              default: begin
                hit_d = lo_q;
                ins_d = 1'b1; mv_d = 1'b0; ptr_d = count_q;
              end
            endcase
          end
        endcase
      end
      skte_pkg::S_SHIFT: begin
        if (ins_q) begin
          // Move entry ptr-1 to ptr until ptr reaches the insert position.
          if (mv_q) begin
            we = 1'b1; waddr = ptr_q[AW-1:0];
            ptr_d = ptr_q - CW'(1); mv_d = 1'b0;
          end else if (ptr_q != CW'(hit_q)) begin
            mv_d = 1'b1;
          end
        end else begin
          // Move entry ptr+1 to ptr until ptr+1 reaches the count.
          if (mv_q) begin
            we = 1'b1; waddr = ptr_q[AW-1:0];
            ptr_d = ptr_q + CW'(1); mv_d = 1'b0;
          end else if ((ptr_q + CW'(1)) >= count_q) begin
            count_d = count_q - CW'(1);
          end else begin
            mv_d = 1'b1;
          end
        end
      end
      skte_pkg::S_WRITE: begin
        we = 1'b1; waddr = hit_q[AW-1:0]; wkey = key_q; wval = val_q;
        count_d = count_q + CW'(1);
        ins_d = 1'b0;
      end
      skte_pkg::S_FGET: begin
        if (hit_q >= 0 && hit_q < cnt_s && (!chk_q || cmp.eq)) begin
          rk_d = rkey; rv_d = rval;
          if (stat_q == skte_pkg::StMiss) stat_d = skte_pkg::StOk;
        end else begin
          hit_d = '0; rk_d = '0; rv_d = '0;
          if (stat_q != skte_pkg::StFull) stat_d = skte_pkg::StMiss;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == skte_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == skte_pkg::S_OUT);

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[1:0]      = stat_q;
    m_axis_tdata[9:2]      = 8'(hit_q);
    m_axis_tdata[10 +: KW] = rk_q[KW-1:0];
    m_axis_tdata[42 +: VW] = rv_q[VW-1:0];
    m_axis_tdata[82:74]    = 9'(count_q);
  end
endmodule
`default_nettype wire

### test/tb_sorted_key_table_engine.sv
// Testbench for sorted_key_table_engine: drives key table operations over the
// streaming ports and checks every result word against a local table model.
// Depends on skte_pkg and the engine RTL only.
`timescale 1ns / 1ps
module tb_sorted_key_table_engine;

  localparam int TableSize = 256;

  // Mirror of the key table; predicts the result word of each operation.
  class key_table_scoreboard;
    logic [31:0] keys [TableSize+1];
    logic [31:0] vals [TableSize+1];
    int          count;
    bit          key_signed;
    int          accepted;
    int          errors;
    logic [87:0] awaited [$];

    function new();
      count = 0;
      key_signed = 1'b1;
      accepted = 0;
      errors = 0;
    endfunction

    function int order(logic [31:0] a, logic [31:0] b);
      if (key_signed) begin
        a ^= 32'h8000_0000;
        b ^= 32'h8000_0000;
      end
      if (a < b) return -1;
      if (a > b) return 1;
      return 0;
    endfunction

    // Binary search that stops at the first equal key probed.
    function void exact_search(input logic [31:0] k, output int eq, output int nx);
      int lo, hi, mid, d;
      lo = 0;
      hi = count - 1;
      eq = -1;
      nx = -1;
      while (lo <= hi) begin
        mid = lo + ((hi - lo) >> 1);
        d = order(keys[mid], k);
        if (d < 0) lo = mid + 1;
        else if (d > 0) begin
          nx = mid;
          hi = mid - 1;
        end else begin
          eq = mid;
          return;
        end
      end
    endfunction

    // First index with key >= k, or > k when strict.
    function int lower_bound(logic [31:0] k, bit strict);
      int lo, hi, mid, d;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        d = order(keys[mid], k);
        if (d < 0 || (strict && d == 0)) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void place(int pos, logic [31:0] k, logic [31:0] v);
      for (int i = count; i > pos; i--) begin
        keys[i] = keys[i-1];
        vals[i] = vals[i-1];
      end
      keys[pos] = k;
      vals[pos] = v;
      count++;
    endfunction

    function void note(logic [3:0] op, logic [31:0] k, logic [31:0] v, logic [7:0] off);
      int eq, nx, b, hit;
      logic [1:0] st;
      logic [31:0] rk, rv;
      st = skte_pkg::StMiss;
      hit = -1;
      rk = '0;
      rv = '0;
      accepted++;
      case (op)
        skte_pkg::OpGet: begin
          exact_search(k, eq, nx);
          hit = eq;
        end
        skte_pkg::OpGte: begin
          exact_search(k, eq, nx);
          hit = (eq >= 0) ? eq : nx;
        end
        skte_pkg::OpLte: begin
          exact_search(k, eq, nx);
          hit = (eq >= 0) ? eq : lower_bound(k, 1'b0) - 1;
        end
        skte_pkg::OpGt: begin
          b = lower_bound(k, 1'b1);
          hit = (b < count) ? b : -1;
        end
        skte_pkg::OpLt: hit = lower_bound(k, 1'b0) - 1;
        skte_pkg::OpInsert: begin
          exact_search(k, eq, nx);
          if (eq >= 0) begin
            hit = eq;
            st = skte_pkg::StPresent;
          end else if (count >= TableSize) begin
            st = skte_pkg::StFull;
          end else begin
            b = (nx >= 0) ? nx : count;
            place(b, k, v);
            hit = b;
          end
        end
        skte_pkg::OpDelete: begin
          exact_search(k, eq, nx);
          if (eq >= 0) begin
            rk = keys[eq];
            rv = vals[eq];
            for (int i = eq; i + 1 < count; i++) begin
              keys[i] = keys[i+1];
              vals[i] = vals[i+1];
            end
            count--;
            awaited.push_back({5'd0, 9'(count), rv, rk, 8'(eq), skte_pkg::StOk});
            return;
          end
        end
        skte_pkg::OpMGet: begin
          b = lower_bound(k, 1'b0);
          if (b < count && order(keys[b], k) == 0) hit = b;
        end
        skte_pkg::OpMGetAt: begin
          b = lower_bound(k, 1'b0) + int'(off);
          if (b < count && order(keys[b], k) == 0) hit = b;
        end
        skte_pkg::OpMAppend, skte_pkg::OpMPrep: begin
          if (count >= TableSize) st = skte_pkg::StFull;
          else begin
            b = lower_bound(k, op == skte_pkg::OpMAppend);
            place(b, k, v);
            hit = b;
          end
        end
        default: ;
      endcase
      if (hit >= 0 && hit < count) begin
        if (st == skte_pkg::StMiss) st = skte_pkg::StOk;
        rk = keys[hit];
        rv = vals[hit];
      end else begin
        hit = 0;
        if (st != skte_pkg::StFull) st = skte_pkg::StMiss;
      end
      awaited.push_back({5'd0, 9'(count), rv, rk, 8'(hit), st});
    endfunction

    function void check(logic [87:0] got);
      logic [87:0] want;
      if (awaited.size() == 0) begin
        $display("%0t: result word with none awaited: %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got[1:0] !== want[1:0])
        $display("%0t: status expected %0d actual %0d", $time, want[1:0], got[1:0]);
      if (got[9:2] !== want[9:2])
        $display("%0t: position expected %0d actual %0d", $time, want[9:2], got[9:2]);
      if (got[41:10] !== want[41:10])
        $display("%0t: found_key expected %h actual %h", $time, want[41:10], got[41:10]);
      if (got[73:42] !== want[73:42])
        $display("%0t: found_value expected %h actual %h", $time, want[73:42], got[73:42]);
      if (got[82:74] !== want[82:74])
        $display("%0t: entry_total expected %0d actual %0d", $time, want[82:74], got[82:74]);
      if (got[82:0] !== want[82:0]) errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  key_table_scoreboard table_sb = new();
  bit no_gaps = 1'b0;   // set for a stretch in which neither side idles
  bit hold_done = 1'b0;

  sorted_key_table_engine dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Offer one word; valid stays high until the engine takes it.
  task automatic send_word(logic [3:0] op, logic [31:0] k, logic [31:0] v, logic [7:0] off);
    while (!no_gaps && $urandom_range(99) < 6) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    forever begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {4'd0, off, v, k, op};
      #1;
      if (s_axis_tready) begin
        @(posedge clk_i);
        table_sb.note(op, k, v, off);
        break;
      end
    end
  endtask

  // Wait until every awaited word has arrived and the engine has settled.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (table_sb.awaited.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_key_signed(bit val);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    table_sb.key_signed = val;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom;
      1: case ($urandom_range(5))
           0: return 32'h0000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h8000_0000;
           3: return 32'hFFFF_FFFF;
           4: return 32'h8000_0001;
           default: return 32'h7FFF_FFFE;
         endcase
      2: return $urandom_range(15);
      default: return 32'hFFFF_FFF0 + $urandom_range(15);
    endcase
  endfunction

  task automatic random_words(int n);
    logic [3:0] op;
    logic [7:0] off;
    repeat (n) begin
      op = ($urandom_range(99) < 4) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(10));
      off = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      send_word(op, pick_key(), $urandom, off);
    end
  endtask

  // Receiving side, with one long hold-off that backs the engine up.
  initial begin
    bit rdy;
    forever begin
      @(negedge clk_i);
      if (!hold_done && table_sb.accepted >= 60) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      rdy = no_gaps || ($urandom_range(99) >= 6);
      m_axis_tready <= rdy;
      #1;
      if (rdy && m_axis_tvalid) begin
        @(posedge clk_i);
        table_sb.check(m_axis_tdata);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_key_signed(1'b1);

    // Directed: empty table, extremes, duplicates and run offsets.
    send_word(skte_pkg::OpGet, 32'h0, 32'h0, 8'd0);
    send_word(skte_pkg::OpGt, 32'h0, 32'h0, 8'd0);
    send_word(skte_pkg::OpLt, 32'h0, 32'h0, 8'd0);
    send_word(skte_pkg::OpDelete, 32'h5, 32'h0, 8'd0);
    send_word(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_word(skte_pkg::OpInsert, 32'h8000_0000, 32'h0, 8'd0);
    send_word(skte_pkg::OpInsert, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    send_word(skte_pkg::OpInsert, 32'h0, 32'hA5A5_A5A5, 8'd0);
    send_word(skte_pkg::OpInsert, 32'h0, 32'h5A5A_5A5A, 8'd0);
    send_word(skte_pkg::OpMAppend, 32'h0, 32'h1111_1111, 8'd0);
    send_word(skte_pkg::OpMPrep, 32'h0, 32'h2222_2222, 8'd0);
    send_word(skte_pkg::OpMGet, 32'h0, 32'h0, 8'd0);
    send_word(skte_pkg::OpMGetAt, 32'h0, 32'h0, 8'd2);
    send_word(skte_pkg::OpMGetAt, 32'h0, 32'h0, 8'd3);
    send_word(skte_pkg::OpMGetAt, 32'h0, 32'h0, 8'hFF);
    send_word(skte_pkg::OpGte, 32'h1, 32'h0, 8'd0);
    send_word(skte_pkg::OpLte, 32'h1, 32'h0, 8'd0);
    send_word(skte_pkg::OpGt, 32'h0, 32'h0, 8'd0);
    send_word(skte_pkg::OpLt, 32'h0, 32'h0, 8'd0);
    send_word(skte_pkg::OpGt, 32'h7FFF_FFFF, 32'h0, 8'd0);
    send_word(skte_pkg::OpLt, 32'h8000_0000, 32'h0, 8'd0);
    send_word(skte_pkg::OpGet, 32'hFFFF_FFFF, 32'h0, 8'd0);
    send_word(skte_pkg::OpDelete, 32'h0, 32'h0, 8'd0);
    send_word(4'd11, 32'h0, 32'h0, 8'd0);

    random_words(100);

    // Unsigned order over a table sorted as signed, then fresh content.
    write_key_signed(1'b0);
    random_words(60);

    // Fill to capacity without idling, then push against the full table.
    no_gaps = 1'b1;
    while (table_sb.count < TableSize)
      send_word(skte_pkg::OpMAppend, $urandom_range(40), $urandom, 8'd0);
    send_word(skte_pkg::OpInsert, 32'h1234_5678, 32'h0, 8'd0);
    send_word(skte_pkg::OpMAppend, 32'h3, 32'h0, 8'd0);
    send_word(skte_pkg::OpMPrep, 32'hFFFF_FFFF, 32'h0, 8'd0);
    send_word(skte_pkg::OpMGetAt, 32'h5, 32'h0, 8'd1);
    no_gaps = 1'b0;
    repeat (40) send_word(skte_pkg::OpDelete, $urandom_range(40), 32'h0, 8'd0);

    write_key_signed(1'b1);
    random_words(60);

    drain();
    if (table_sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
